### rtl/sgr_pkg.sv
package sgr_pkg;

    localparam int CODE_W   = 8;
    localparam int SCALE_W  = 4;
    localparam int GLYPH_W  = 15;
    localparam int INK_W    = 24;
    localparam int ROWNUM_W = 6;
    localparam int GROW_W   = 3;

    // Largest magnification; writes above it saturate.
    localparam logic [SCALE_W-1:0] MAX_SCALE = 4'd8;
    localparam logic [GROW_W-1:0]  LAST_GLYPH_ROW = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic load_glyph;
        logic emit_row;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic final_row;
    } dp_status_t;

    // Packed glyph: row r in bits 3r+2..3r, leftmost pixel in the high bit of each row.
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CODE_W-1:0] code);
        logic [GLYPH_W-1:0] g;
        begin
            unique case (code)
                8'h2B:   g = {3'h0, 3'h2, 3'h7, 3'h2, 3'h0}; // '+'
                8'h2D:   g = {3'h0, 3'h0, 3'h7, 3'h0, 3'h0}; // '-'
                8'h54:   g = {3'h2, 3'h2, 3'h2, 3'h2, 3'h7}; // 'T'
                8'h4F:   g = {3'h7, 3'h5, 3'h5, 3'h5, 3'h7}; // 'O'
                8'h50:   g = {3'h4, 3'h4, 3'h7, 3'h5, 3'h7}; // 'P'
                8'h46:   g = {3'h4, 3'h4, 3'h7, 3'h4, 3'h7}; // 'F'
                8'h52:   g = {3'h5, 3'h6, 3'h7, 3'h5, 3'h7}; // 'R'
                8'h4E:   g = {3'h5, 3'h5, 3'h7, 3'h7, 3'h5}; // 'N'
                8'h53:   g = {3'h7, 3'h1, 3'h7, 3'h4, 3'h7}; // 'S'
                8'h49:   g = {3'h7, 3'h2, 3'h2, 3'h2, 3'h7}; // 'I'
                8'h44:   g = {3'h6, 3'h5, 3'h5, 3'h5, 3'h6}; // 'D'
                8'h45:   g = {3'h7, 3'h4, 3'h7, 3'h4, 3'h7}; // 'E'
                8'h42:   g = {3'h6, 3'h5, 3'h6, 3'h5, 3'h6}; // 'B'
                8'h58:   g = {3'h5, 3'h5, 3'h2, 3'h5, 3'h5}; // 'X'
                8'h59:   g = {3'h2, 3'h2, 3'h2, 3'h5, 3'h5}; // 'Y'
                8'h5A:   g = {3'h7, 3'h4, 3'h2, 3'h1, 3'h7}; // 'Z'
                8'h41:   g = {3'h5, 3'h5, 3'h7, 3'h5, 3'h2}; // 'A'
                8'h43:   g = {3'h3, 3'h4, 3'h4, 3'h4, 3'h3}; // 'C'
                8'h4B:   g = {3'h5, 3'h6, 3'h4, 3'h6, 3'h5}; // 'K'
                default: g = '0;                               // space and unknown codes
            endcase
            return g;
        end
    endfunction

endpackage

### rtl/sgr_ctrl.sv
module sgr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sgr_pkg::dp_status_t status,
    output sgr_pkg::ctrl_cmd_t  cmd
);
    import sgr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd.load_glyph = 1'b0;
        cmd.emit_row   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_glyph = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // One row leaves whenever the output register can take it.
                if (status.out_free)
                begin
                    cmd.emit_row = 1'b1;
                    if (status.final_row)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sgr_datapath.sv
module sgr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [sgr_pkg::SCALE_W-1:0]   cfg_data,
    input  logic [sgr_pkg::CODE_W-1:0]    char_code,
    input  sgr_pkg::ctrl_cmd_t            cmd,
    output sgr_pkg::dp_status_t           status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sgr_pkg::INK_W-1:0]     ink_row,
    output logic [sgr_pkg::ROWNUM_W-1:0]  row_number,
    output logic                          last_row
);
    import sgr_pkg::*;

    logic [SCALE_W-1:0]  scale_reg;
    logic [SCALE_W-1:0]  scale_next;
    logic [GLYPH_W-1:0]  glyph_reg;
    logic [GROW_W-1:0]   grow_reg;
    logic [SCALE_W-1:0]  rep_reg;
    logic [ROWNUM_W-1:0] rownum_reg;
    logic                m_tvalid_reg;
    logic [INK_W-1:0]    ink_reg;
    logic [ROWNUM_W-1:0] out_rownum_reg;
    logic                last_reg;

    logic [3:0]          row_lsb;
    logic [2:0]          row3;
    logic [INK_W-1:0]    ones;
    logic [INK_W-1:0]    ink;
    logic                rep_done;

    // Writes of zero store one, writes above the maximum store the maximum.
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            scale_next = SCALE_W'(1);
        end
        else if (cfg_data > MAX_SCALE)
        begin
            scale_next = MAX_SCALE;
        end
        else
        begin
            scale_next = cfg_data;
        end
    end

    // Font row r starts at bit 3r, formed as r + 2r so that row four reaches bit 12.
    assign row_lsb  = {1'b0, grow_reg} + {grow_reg, 1'b0};

    // Widen the font row: leftmost pixel in columns 0..s-1, then s..2s-1, then 2s..3s-1.
    assign row3     = glyph_reg[row_lsb +: 3];
    assign ones     = (INK_W'(1) << scale_reg) - INK_W'(1);
    assign ink      = (row3[2] ? ones : '0)
                    | (row3[1] ? (ones << scale_reg) : '0)
                    | (row3[0] ? (ones << {scale_reg, 1'b0}) : '0);
    assign rep_done = (rep_reg == scale_reg - SCALE_W'(1));

    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.final_row = rep_done && (grow_reg == LAST_GLYPH_ROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_W'(1);
            glyph_reg    <= '0;
            grow_reg     <= '0;
            rep_reg      <= '0;
            rownum_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                scale_reg <= scale_next;
            end
            if (cmd.load_glyph)
            begin
                glyph_reg  <= glyph_of(char_code);
                grow_reg   <= '0;
                rep_reg    <= '0;
                rownum_reg <= '0;
            end
            else if (cmd.emit_row)
            begin
                rownum_reg <= rownum_reg + ROWNUM_W'(1);
                if (rep_done)
                begin
                    rep_reg  <= '0;
                    grow_reg <= grow_reg + GROW_W'(1);
                end
                else
                begin
                    rep_reg <= rep_reg + SCALE_W'(1);
                end
            end
            if (cmd.emit_row)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_row)
        begin
            ink_reg        <= ink;
            out_rownum_reg <= rownum_reg;
            last_reg       <= status.final_row;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign ink_row    = ink_reg;
    assign row_number = out_rownum_reg;
    assign last_row   = last_reg;

endmodule

### rtl/scaled_glyph_row_generator_core.sv
// Character generator for a fixed 3x5 font of nineteen glyphs. Each input transfer carries one
// character code; codes outside the font draw as a space. The glyph is sent out top row first
// as 5*scale output transfers, one per scaled row, each font pixel widened to scale columns
// (leftmost pixel in bit 0) and each row repeated scale times; tlast marks the final row.
// The scale register is written through the cfg channel, resets to 1 and saturates to 1..8.
// Rows leave at one per clock while the output side accepts them. A character is handled in
// two steps: the code is taken and its glyph looked up, then its rows pass one by one
// through the single output register. The next code is taken as soon as the final row of the
// previous one sits in the output register, so input and output overlap by that one row.
module scaled_glyph_row_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write: cfg_data is the scale value.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // Input stream. s_tdata[7:0] = char_code.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Output stream. m_tdata[23:0] = ink_row, [29:24] = row_number, [31:30] = zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import sgr_pkg::*;

    ctrl_cmd_t           cmd;
    dp_status_t          status;
    logic [INK_W-1:0]    ink_row;
    logic [ROWNUM_W-1:0] row_number;

    // The user must write the register only while idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sgr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .char_code  (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .ink_row    (ink_row),
        .row_number (row_number),
        .last_row   (m_tlast)
    );

    assign m_tdata = {2'b00, row_number, ink_row};

    // A glyph load and a row emission never happen in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_glyph && cmd.emit_row))
    else $error("glyph load and row emission coincide");

    // A row is only written into the output register when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_row |-> status.out_free)
    else $error("row emitted over a pending output transfer");

    // After taking a character the block is busy with its rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again while a character is in progress");

    // Every emitted row becomes valid on the output in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_row |=> m_tvalid)
    else $error("emitted row not presented on the output");

endmodule
